### sv/mac_learning_table_aging_unit_assert.svh
// Assertion macros for the MAC learning table aging unit.
// Included by modules that check their own control logic; no other dependencies.
`ifndef MAC_LEARNING_TABLE_AGING_UNIT_ASSERT_SVH
`define MAC_LEARNING_TABLE_AGING_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MLTA_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MLTA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MLTA_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define MLTA_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

### sv/mlta_pkg.sv
// Shared types and constants of the MAC learning table aging unit.
// No dependencies; used by mlta_cell, mlta_ctrl and the top level.
package mlta_pkg;

   localparam int MAC_W   = 48;
   localparam int LINK_W  = 16;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int COUNT_W = 7;
   localparam int GROUP_BIT = 40;

   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_LEARN  = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;

   localparam logic [1:0] CSR_SWEEP_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_STALE_TIMEOUT  = 2'd1;
   localparam logic [1:0] CSR_BROADCAST_ID   = 2'd2;

   localparam logic [CFG_W-1:0] SWEEP_INTERVAL_RST = 16'd300;
   localparam logic [CFG_W-1:0] STALE_TIMEOUT_RST  = 16'd300;
   localparam logic [CFG_W-1:0] BROADCAST_ID_RST   = 16'd65535;

   typedef enum logic [1:0] {
      OP_LOOKUP,
      OP_SEARCH,
      OP_CLAIM,
      OP_SWEEP
   } op_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [MAC_W-1:0]  mac_addr;
      logic [LINK_W-1:0] link_in;
   } req_type;

   typedef struct packed {
      logic [LINK_W-1:0]  link_out;
      logic               found;
      logic               added;
      logic               full_drop;
      logic [COUNT_W-1:0] removed_count;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      op_type             op;
      logic [MAC_W-1:0]   mac;
      logic [LINK_W-1:0]  link;
      logic [TIME_W-1:0]  stamp;
      logic [CFG_W-1:0]   timeout;
      logic               hit;
      logic [COUNT_W-1:0] count;
   } token_type;

endpackage

### sv/mlta_cell.sv
// One table slot of the MAC learning table: holds an entry and passes the token on.
// Depends on mlta_pkg.
module mlta_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  mlta_pkg::token_type  tok_in,
   output mlta_pkg::token_type  tok_out
);

   logic                          valid_ff, valid_in;
   logic [mlta_pkg::MAC_W-1:0]    mac_ff, mac_in;
   logic [mlta_pkg::LINK_W-1:0]   link_ff, link_in;
   logic [mlta_pkg::TIME_W-1:0]   expiry_ff, expiry_in;
   mlta_pkg::token_type           tok_ff, tok_nxt;
   logic                          match;
   logic                          stale;
   logic [mlta_pkg::TIME_W-1:0]   diff;

   always_comb begin
      match = valid_ff && (mac_ff == tok_in.mac);
      diff  = tok_in.stamp - expiry_ff;
      stale = valid_ff && !diff[mlta_pkg::TIME_W-1] &&
              (diff > {{(mlta_pkg::TIME_W-mlta_pkg::CFG_W){1'b0}}, tok_in.timeout});
      tok_nxt   = tok_in;
      valid_in  = valid_ff;
      mac_in    = mac_ff;
      link_in   = link_ff;
      expiry_in = expiry_ff;
      if (tok_in.valid) begin
         case (tok_in.op)
            mlta_pkg::OP_LOOKUP: begin
               if (!tok_in.hit && match && !tok_in.mac[mlta_pkg::GROUP_BIT]) begin
                  tok_nxt.hit  = 1'b1;
                  tok_nxt.link = link_ff;
               end
            end
            mlta_pkg::OP_SEARCH: begin
               if (!tok_in.hit && match) begin
                  tok_nxt.hit = 1'b1;
                  expiry_in   = tok_in.stamp;
               end
            end
            mlta_pkg::OP_CLAIM: begin
               if (!tok_in.hit && !valid_ff) begin
                  tok_nxt.hit = 1'b1;
                  valid_in    = 1'b1;
                  mac_in      = tok_in.mac;
                  link_in     = tok_in.link;
                  expiry_in   = tok_in.stamp;
               end
            end
            mlta_pkg::OP_SWEEP: begin
               if (stale) begin
                  valid_in      = 1'b0;
                  tok_nxt.count = tok_in.count + 7'd1;
               end
            end
            default: begin
               tok_nxt = tok_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_nxt;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff    <= mac_in;
      link_ff   <= link_in;
      expiry_ff <= expiry_in;
   end

   assign tok_out = tok_ff;

endmodule

### sv/mlta_ctrl.sv
// Command sequencer of the MAC learning table: registers, time base, token launch, results.
// Depends on mlta_pkg and mac_learning_table_aging_unit_assert.svh.
`include "mac_learning_table_aging_unit_assert.svh"

module mlta_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  mlta_pkg::req_type           req_item,
   input  logic                        csr_valid,
   input  logic [1:0]                  csr_index,
   input  logic [mlta_pkg::CFG_W-1:0]  csr_wdata,
   output mlta_pkg::token_type         tok_launch,
   input  mlta_pkg::token_type         tok_return,
   output logic                        rsp_valid,
   output mlta_pkg::rsp_type           rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_LEARN,
      ST_CLAIM,
      ST_SWEEP
   } state_type;

   state_type                     state_ff, state_in;
   logic [mlta_pkg::CFG_W-1:0]    interval_ff, interval_in;
   logic [mlta_pkg::CFG_W-1:0]    timeout_ff, timeout_in;
   logic [mlta_pkg::CFG_W-1:0]    bcast_ff, bcast_in;
   logic [mlta_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [mlta_pkg::CFG_W-1:0]    ticks_ff, ticks_in;
   logic [mlta_pkg::CFG_W-1:0]    ticks_inc;
   mlta_pkg::token_type           launch_ff, launch_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   mlta_pkg::rsp_type             rsp_ff, rsp_in;

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      timeout_in   = timeout_ff;
      bcast_in     = bcast_ff;
      now_in       = now_ff;
      ticks_in     = ticks_ff;
      ticks_inc    = ticks_ff + 16'd1;
      launch_in    = launch_ff;
      launch_in.valid = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      if (csr_valid) begin
         case (csr_index)
            mlta_pkg::CSR_SWEEP_INTERVAL: interval_in = csr_wdata;
            mlta_pkg::CSR_STALE_TIMEOUT:  timeout_in  = csr_wdata;
            mlta_pkg::CSR_BROADCAST_ID:   bcast_in    = csr_wdata;
            default:                      interval_in = interval_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               launch_in.mac     = req_item.mac_addr;
               launch_in.link    = req_item.link_in;
               launch_in.timeout = timeout_ff;
               launch_in.hit     = 1'b0;
               launch_in.count   = '0;
               launch_in.stamp   = now_ff;
               case (req_item.func)
                  mlta_pkg::FUNC_LOOKUP: begin
                     launch_in.valid = 1'b1;
                     launch_in.op    = mlta_pkg::OP_LOOKUP;
                     state_in        = ST_LOOKUP;
                  end
                  mlta_pkg::FUNC_LEARN: begin
                     launch_in.valid = 1'b1;
                     launch_in.op    = mlta_pkg::OP_SEARCH;
                     launch_in.stamp = now_ff + {16'd0, timeout_ff};
                     state_in        = ST_LEARN;
                  end
                  mlta_pkg::FUNC_TICK: begin
                     now_in = now_ff + 32'd1;
                     if (ticks_inc >= interval_ff) begin
                        ticks_in        = '0;
                        launch_in.valid = 1'b1;
                        launch_in.op    = mlta_pkg::OP_SWEEP;
                        launch_in.stamp = now_ff + 32'd1;
                        state_in        = ST_SWEEP;
                     end else begin
                        ticks_in     = ticks_inc;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (tok_return.valid) begin
               rsp_valid_in    = 1'b1;
               rsp_in.found    = tok_return.hit;
               rsp_in.link_out = tok_return.hit ? tok_return.link : bcast_ff;
               state_in        = ST_IDLE;
            end
         end
         ST_LEARN: begin
            if (tok_return.valid) begin
               if (tok_return.hit) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.found = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  launch_in       = tok_return;
                  launch_in.op    = mlta_pkg::OP_CLAIM;
                  launch_in.hit   = 1'b0;
                  state_in        = ST_CLAIM;
               end
            end
         end
         ST_CLAIM: begin
            if (tok_return.valid) begin
               rsp_valid_in     = 1'b1;
               rsp_in.added     = tok_return.hit;
               rsp_in.full_drop = !tok_return.hit;
               state_in         = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (tok_return.valid) begin
               rsp_valid_in         = 1'b1;
               rsp_in.removed_count = tok_return.count;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         interval_ff     <= mlta_pkg::SWEEP_INTERVAL_RST;
         timeout_ff      <= mlta_pkg::STALE_TIMEOUT_RST;
         bcast_ff        <= mlta_pkg::BROADCAST_ID_RST;
         now_ff          <= '0;
         ticks_ff        <= '0;
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         timeout_ff   <= timeout_in;
         bcast_ff     <= bcast_in;
         now_ff       <= now_in;
         ticks_ff     <= ticks_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign tok_launch = launch_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   `MLTA_ASSERT_IMPL(a_ret_only_busy, clock, reset, tok_return.valid, state_ff != ST_IDLE,
      "token returned while idle")
   `MLTA_ASSERT_NEXT(a_launch_pulse, clock, reset, launch_ff.valid, !launch_ff.valid,
      "token launched on two cycles in a row")
   `MLTA_ASSERT_IMPL(a_learn_flags, clock, reset, rsp_valid_ff,
      !(rsp_ff.added && rsp_ff.full_drop) && !(rsp_ff.added && rsp_ff.found),
      "conflicting learn flags")
   `MLTA_ASSERT_IMPL(a_launch_busy, clock, reset, launch_ff.valid, state_ff != ST_IDLE,
      "token launched without waiting for it")

endmodule

### sv/mac_learning_table_aging_unit.sv
// Top level of the MAC learning table with aging: sequencer plus a chain of table cells.
// Depends on mlta_pkg, mlta_ctrl and mlta_cell.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   request  | start / busy         | req_item  (func, mac, link)
//   result   | rsp_valid strobe     | rsp_item  (link, flags, count)
//   config   | csr_valid/csr_ready  | csr_index, csr_wdata
//
// A token walks the cell chain one cell per cycle: lookup and sweeping tick pass the chain
// once, a learn of a known address once (search), a learn of a new address twice (search,
// then claim); a tick without sweep and an unused func are answered without a token.
// Synchronous reset clears all entries at once; no clearing pass.
// The result strobe lasts one cycle and cannot be held off.
module mac_learning_table_aging_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  mlta_pkg::req_type           req_item,
   output logic                        rsp_valid,
   output mlta_pkg::rsp_type           rsp_item,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [mlta_pkg::CFG_W-1:0]  csr_wdata
);

   mlta_pkg::token_type chain [0:TABLE_DEPTH];

   assign csr_ready = 1'b1;

   mlta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .tok_launch (chain[0]),
      .tok_return (chain[TABLE_DEPTH]),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      mlta_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

endmodule

### tb/tb_top.sv
// Self-checking testbench for mac_learning_table_aging_unit: random and directed
// learn/lookup/tick traffic checked against a table predictor. Needs mlta_pkg too.
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH = 64;
   localparam int POOL_SIZE = 96;
   localparam int PHASE_ITEMS = 370;
   localparam int MAC_W   = mlta_pkg::MAC_W;
   localparam int LINK_W  = mlta_pkg::LINK_W;
   localparam int TIME_W  = mlta_pkg::TIME_W;
   localparam int CFG_W   = mlta_pkg::CFG_W;
   localparam int COUNT_W = mlta_pkg::COUNT_W;
   localparam logic [1:0] FUNC_UNDEFINED = 2'd3;

   typedef struct {
      logic               is_csr;
      mlta_pkg::req_type  req;
      logic [1:0]         index;
      logic [CFG_W-1:0]   wdata;
   } table_op_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   mlta_pkg::req_type   req_item = '0;
   logic                rsp_valid;
   mlta_pkg::rsp_type   rsp_item;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = mlta_pkg::CSR_SWEEP_INTERVAL;
   logic [CFG_W-1:0]    csr_wdata = '0;

   table_op_type        pending_ops[$];
   mlta_pkg::rsp_type   expected_responses[$];
   int unsigned         issued_count = 0;
   int unsigned         retired_count = 0;
   int                  errors = 0;
   int                  gap_left = 0;
   int                  quiet_run = 0;
   logic [MAC_W-1:0]    station_pool[POOL_SIZE];

   // predicted table state and registers
   logic              station_valid[DEPTH];
   logic [MAC_W-1:0]  station_mac[DEPTH];
   logic [LINK_W-1:0] station_link[DEPTH];
   logic [TIME_W-1:0] station_expiry[DEPTH];
   logic [TIME_W-1:0] now_secs = '0;
   logic [CFG_W-1:0]  ticks_since_sweep = '0;
   logic [CFG_W-1:0]  cfg_sweep_interval = mlta_pkg::SWEEP_INTERVAL_RST;
   logic [CFG_W-1:0]  cfg_stale_timeout = mlta_pkg::STALE_TIMEOUT_RST;
   logic [CFG_W-1:0]  cfg_broadcast_id = mlta_pkg::BROADCAST_ID_RST;

   mac_learning_table_aging_unit #(.TABLE_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int find_station(input logic [MAC_W-1:0] mac);
      for (int i = 0; i < DEPTH; i++) begin
         if (station_valid[i] && station_mac[i] == mac) return i;
      end
      return -1;
   endfunction

   function automatic mlta_pkg::rsp_type predict_table_response(input mlta_pkg::req_type r);
      mlta_pkg::rsp_type rsp;
      int                slot;
      int                removed;
      logic [TIME_W-1:0] age;
      rsp = '0;
      removed = 0;
      case (r.func)
         mlta_pkg::FUNC_LOOKUP: begin
            rsp.link_out = cfg_broadcast_id;
            if (!r.mac_addr[mlta_pkg::GROUP_BIT]) begin
               slot = find_station(r.mac_addr);
               if (slot >= 0) begin
                  rsp.link_out = station_link[slot];
                  rsp.found = 1'b1;
               end
            end
         end
         mlta_pkg::FUNC_LEARN: begin
            slot = find_station(r.mac_addr);
            if (slot >= 0) begin
               rsp.found = 1'b1;
               station_expiry[slot] = now_secs + TIME_W'(cfg_stale_timeout);
            end else begin
               for (int i = 0; i < DEPTH && slot < 0; i++) begin
                  if (!station_valid[i]) slot = i;
               end
               if (slot >= 0) begin
                  station_valid[slot] = 1'b1;
                  station_mac[slot] = r.mac_addr;
                  station_link[slot] = r.link_in;
                  station_expiry[slot] = now_secs + TIME_W'(cfg_stale_timeout);
                  rsp.added = 1'b1;
               end else begin
                  rsp.full_drop = 1'b1;
               end
            end
         end
         mlta_pkg::FUNC_TICK: begin
            now_secs = now_secs + 1'b1;
            ticks_since_sweep = ticks_since_sweep + 1'b1;
            if (ticks_since_sweep >= cfg_sweep_interval) begin
               ticks_since_sweep = '0;
               for (int i = 0; i < DEPTH; i++) begin
                  age = now_secs - station_expiry[i];
                  if (station_valid[i] && !age[TIME_W-1] &&
                      age > TIME_W'(cfg_stale_timeout)) begin
                     station_valid[i] = 1'b0;
                     removed++;
                  end
               end
            end
            rsp.removed_count = COUNT_W'(removed);
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic void apply_csr_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
         mlta_pkg::CSR_SWEEP_INTERVAL: cfg_sweep_interval = data;
         mlta_pkg::CSR_STALE_TIMEOUT:  cfg_stale_timeout = data;
         mlta_pkg::CSR_BROADCAST_ID:   cfg_broadcast_id = data;
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_run > 0) begin
         quiet_run--;
         return 0;
      end
      if (roll < 4) begin
         quiet_run = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_op(input logic [1:0] func, input logic [MAC_W-1:0] mac,
                          input logic [LINK_W-1:0] link);
      table_op_type op;
      op.is_csr = 1'b0;
      op.req.func = func;
      op.req.mac_addr = mac;
      op.req.link_in = link;
      op.index = mlta_pkg::CSR_SWEEP_INTERVAL;
      op.wdata = '0;
      pending_ops.push_back(op);
   endtask

   task automatic push_csr(input logic [1:0] idx, input logic [CFG_W-1:0] data);
      table_op_type op;
      op.is_csr = 1'b1;
      op.req = '0;
      op.index = idx;
      op.wdata = data;
      pending_ops.push_back(op);
   endtask

   task automatic push_config(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] timeout,
                              input logic [CFG_W-1:0] bcast);
      push_csr(mlta_pkg::CSR_SWEEP_INTERVAL, interval);
      push_csr(mlta_pkg::CSR_STALE_TIMEOUT, timeout);
      push_csr(mlta_pkg::CSR_BROADCAST_ID, bcast);
   endtask

   task automatic push_random_op();
      int               roll;
      logic [1:0]       func;
      logic [MAC_W-1:0] mac;
      roll = $urandom_range(0, 99);
      if (roll < 38) func = mlta_pkg::FUNC_LEARN;
      else if (roll < 75) func = mlta_pkg::FUNC_LOOKUP;
      else if (roll < 96) func = mlta_pkg::FUNC_TICK;
      else func = FUNC_UNDEFINED;
      if ($urandom_range(0, 99) < 88) mac = station_pool[$urandom_range(0, POOL_SIZE - 1)];
      else mac = MAC_W'({$urandom, $urandom});
      push_op(func, mac, LINK_W'($urandom_range(0, 65535)));
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   // driver: one transaction at a time, config writes only once the table is idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_responses.push_back(predict_table_response(req_item));
            issued_count <= issued_count + 1;
         end
         if (csr_valid && csr_ready) apply_csr_write(csr_index, csr_wdata);

         if (start && busy) begin
            // hold
         end else if (csr_valid && !csr_ready) begin
            // hold
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
            csr_valid <= 1'b0;
         end else if (pending_ops.size() != 0 && !pending_ops[0].is_csr) begin
            start <= 1'b1;
            req_item <= pending_ops[0].req;
            csr_valid <= 1'b0;
            void'(pending_ops.pop_front());
            gap_left = pick_gap();
         end else if (pending_ops.size() != 0 && !start && !busy &&
                      issued_count == retired_count) begin
            csr_valid <= 1'b1;
            csr_index <= pending_ops[0].index;
            csr_wdata <= pending_ops[0].wdata;
            void'(pending_ops.pop_front());
         end else begin
            start <= 1'b0;
            csr_valid <= 1'b0;
         end
      end
   end

   // monitor: every strobe is one result transaction
   always @(posedge clock) begin
      mlta_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            $error("result transaction with no request outstanding");
            errors++;
         end else begin
            want = expected_responses.pop_front();
            retired_count <= retired_count + 1;
            check_field("link_out", want.link_out, rsp_item.link_out);
            check_field("found", want.found, rsp_item.found);
            check_field("added", want.added, rsp_item.added);
            check_field("full_drop", want.full_drop, rsp_item.full_drop);
            check_field("removed_count", want.removed_count, rsp_item.removed_count);
         end
      end
   end

   initial begin
      logic [MAC_W-1:0] known;
      known = 48'h0200_1122_3344;
      foreach (station_valid[i]) begin
         station_valid[i] = 1'b0;
         station_mac[i] = '0;
         station_link[i] = '0;
         station_expiry[i] = '0;
      end
      foreach (station_pool[i]) station_pool[i] = MAC_W'({$urandom, $urandom});

      push_config(16'd2, 16'd3, 16'h5A5A);
      push_op(mlta_pkg::FUNC_LOOKUP, '0, 16'h0000);
      push_op(mlta_pkg::FUNC_LOOKUP, 48'h0100_0000_0000, 16'hFFFF);
      push_op(mlta_pkg::FUNC_LEARN, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
      push_op(mlta_pkg::FUNC_LEARN, '0, 16'h0000);
      push_op(mlta_pkg::FUNC_LEARN, known, 16'h1234);
      push_op(mlta_pkg::FUNC_LOOKUP, known, 16'h0000);
      push_op(mlta_pkg::FUNC_LOOKUP, '0, 16'hFFFF);
      push_op(mlta_pkg::FUNC_LOOKUP, 48'hFFFF_FFFF_FFFF, 16'h0000);
      push_op(mlta_pkg::FUNC_LEARN, known, 16'h0BAD);
      push_op(mlta_pkg::FUNC_LOOKUP, known, 16'h0000);
      push_op(FUNC_UNDEFINED, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
      repeat (8) push_op(mlta_pkg::FUNC_TICK, MAC_W'({$urandom, $urandom}), LINK_W'($urandom));
      push_op(mlta_pkg::FUNC_LEARN, 48'hFEFF_FFFF_FFFF, 16'h8000);
      push_op(mlta_pkg::FUNC_LOOKUP, 48'hFEFF_FFFF_FFFF, 16'h0000);
      push_op(mlta_pkg::FUNC_LEARN, known, 16'h0001);
      push_op(mlta_pkg::FUNC_LOOKUP, '0, 16'h0000);

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: push_config(16'd1, 16'd0, CFG_W'($urandom_range(0, 65535)));
            1: push_config(16'd65535, 16'd30, 16'h0000);
            2: push_config(16'd0, 16'd1, 16'hFFFF);
            3: push_config(16'd40, 16'd2, 16'h8001);
            default: push_config(16'd3, 16'd65535, CFG_W'($urandom_range(0, 65535)));
         endcase
         repeat (PHASE_ITEMS) push_random_op();
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || start || csr_valid || issued_count != retired_count)
         @(negedge clock);
      repeat (200) @(posedge clock);
      if (expected_responses.size() != 0) begin
         $error("%0d result transactions never arrived", expected_responses.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

### mac_learning_table_aging_unit.f
+incdir+sv
sv/mlta_pkg.sv
sv/mlta_cell.sv
sv/mlta_ctrl.sv
sv/mac_learning_table_aging_unit.sv
tb/tb_top.sv
